### rtl/kdt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the key release debounce tracker
// no dependencies; every other file uses this package

package kdt_pkg;

  localparam int KEY_W       = 8;
  localparam int KEY_COUNT   = 256;
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH);
  localparam int STAMP_W     = 32;
  localparam int DEB_W       = 16;
  localparam int CMD_W       = 2;

  localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(50);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  // one queued key event
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic               press;
    logic [KEY_W-1:0]   key;
  } event_t;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic clear;     // empty all cells
    logic push;      // load push event into the first free cell
    logic shift;     // pop front, every cell takes its rear neighbor
    logic scan_clr;  // zero the match ripple
    logic scan_en;   // advance the match ripple one cell
  } chain_ctl_t;

endpackage

### rtl/kdt_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the debounce tracker items
// depends on kdt_pkg for field widths

interface kdt_in_if;
  logic                      valid;
  logic                      ready;
  logic [kdt_pkg::CMD_W-1:0] command;
  logic [kdt_pkg::KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface kdt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        key_pressed;
  logic                        change_pending;
  logic [kdt_pkg::STAMP_W-1:0] next_change_time;
  logic                        event_dropped;

  modport source (output valid, output key_pressed, output change_pending,
                  output next_change_time, output event_dropped, input ready);
  modport sink   (input valid, input key_pressed, input change_pending,
                  input next_change_time, input event_dropped, output ready);
endinterface

### rtl/kdt_cell.sv
`timescale 1ns / 1ps
// one cell of the event queue chain: holds one event and one match bit
// depends on kdt_pkg

module kdt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kdt_pkg::chain_ctl_t       ctl_i,
  input  logic                      prev_valid_i,
  input  logic                      next_valid_i,
  input  kdt_pkg::event_t           next_ev_i,
  input  kdt_pkg::event_t           push_ev_i,
  input  logic [kdt_pkg::KEY_W-1:0] query_key_i,
  input  logic                      hit_i,
  output logic                      valid_o,
  output kdt_pkg::event_t           ev_o,
  output logic                      hit_o
);
  import kdt_pkg::*;

  logic   valid_q, valid_d;
  event_t ev_q, ev_d;
  logic   hit_q, hit_d;
  logic   load_push;

  // first free cell behind a valid one takes the pushed event
  assign load_push = ctl_i.push && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    ev_d    = ev_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.shift) begin
      valid_d = next_valid_i;
      ev_d    = next_ev_i;
    end else if (load_push) begin
      valid_d = 1'b1;
      ev_d    = push_ev_i;
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (ctl_i.scan_clr) begin
      hit_d = 1'b0;
    end else if (ctl_i.scan_en) begin
      hit_d = hit_i || (valid_q && ev_q.press && (ev_q.key == query_key_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  assign valid_o = valid_q;
  assign ev_o    = ev_q;
  assign hit_o   = hit_q;

endmodule

### rtl/kdt_event_chain.sv
`timescale 1ns / 1ps
// event queue built as a row of kdt_cell, front at cell 0
// depends on kdt_pkg and kdt_cell

module kdt_event_chain (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kdt_pkg::chain_ctl_t       ctl_i,
  input  kdt_pkg::event_t           push_ev_i,
  input  logic [kdt_pkg::KEY_W-1:0] query_key_i,
  output logic                      front_valid_o,
  output kdt_pkg::event_t           front_ev_o,
  output logic                      full_o,
  output logic                      hit_o
);
  import kdt_pkg::*;

  logic [QUEUE_DEPTH-1:0] valid_v;
  logic [QUEUE_DEPTH-1:0] hit_v;
  event_t                 ev_v [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_valid;
    logic   next_valid;
    event_t next_ev;
    logic   hit_in;

    if (i == 0) begin : g_front
      assign prev_valid = 1'b1;
      assign hit_in     = 1'b0;
    end else begin : g_mid
      assign prev_valid = valid_v[i-1];
      assign hit_in     = hit_v[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_ev    = '0;
    end else begin : g_body
      assign next_valid = valid_v[i+1];
      assign next_ev    = ev_v[i+1];
    end

    kdt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_ev_i    (next_ev),
      .push_ev_i    (push_ev_i),
      .query_key_i  (query_key_i),
      .hit_i        (hit_in),
      .valid_o      (valid_v[i]),
      .ev_o         (ev_v[i]),
      .hit_o        (hit_v[i])
    );
  end

  assign front_valid_o = valid_v[0];
  assign front_ev_o    = ev_v[0];
  assign full_o        = valid_v[QUEUE_DEPTH-1];
  assign hit_o         = hit_v[QUEUE_DEPTH-1];

  // occupied cells always form an unbroken run from the front
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_v[QUEUE_DEPTH-1:1] & ~valid_v[QUEUE_DEPTH-2:0]) == '0)
    else $error("event chain has a hole");

  // a pop of a nonempty chain removes exactly one event
  a_pop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.shift && !ctl_i.clear && valid_v[0]
    |=> $countones(valid_v) == $countones($past(valid_v)) - 1)
    else $error("pop did not remove one event");

  // a clear leaves nothing queued
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> valid_v == '0)
    else $error("clear left events queued");

endmodule

### rtl/key_release_debounce_tracker_core.sv
`timescale 1ns / 1ps
// top level of the key release debounce tracker: sequencer, time, held map
// depends on kdt_pkg, kdt_if and kdt_event_chain
//
// usage
//   in_if carries one item per handshake: command (tick, press, release,
//   clear) and key. out_if returns exactly one result item per input item:
//   key_pressed, change_pending, next_change_time, event_dropped.
//   cfg_we_i / cfg_wdata_i write debounce_ticks; write only while idle.
// timing
//   one item at a time. an item is accepted, then drained (one queued event
//   committed per cycle until the front is not ready), then scanned while the
//   pressed match ripples down the 16-cell event chain, then its result is
//   loaded. the scan length follows the chain depth.
// reset
//   time, held map, queue and output valid are cleared at once; debounce
//   returns to 50. no clearing pass is needed.
// stall
//   the result sits in an output register; the next item is accepted while
//   it waits, and the sequencer holds in its result state only when a new
//   result is ready and the old one has not yet been taken.

module key_release_debounce_tracker_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  kdt_in_if.sink                    in_if,
  kdt_out_if.source                 out_if,
  input  logic                      cfg_we_i,
  input  logic [kdt_pkg::DEB_W-1:0] cfg_wdata_i
);
  import kdt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DRAIN  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration and time
  logic [DEB_W-1:0]   deb_q;
  logic [STAMP_W-1:0] time_q, time_d;

  // item context
  logic [KEY_W-1:0] key_q;
  logic             dropped_q, dropped_d;
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;

  // committed key map, one flop per key, cleared together
  logic [KEY_COUNT-1:0] held_q;
  logic                 held_rd_q;

  // output register
  logic               out_valid_q;
  logic               out_pressed_q;
  logic               out_pending_q;
  logic [STAMP_W-1:0] out_next_q;
  logic               out_dropped_q;

  // chain interface
  chain_ctl_t ctl;
  event_t     push_ev;
  logic       front_valid;
  event_t     front_ev;
  logic       chain_full;
  logic       chain_hit;

  logic               accept;
  cmd_e               cmd;
  logic [STAMP_W-1:0] age;
  logic               commit;
  logic               load_out;

  assign cmd    = cmd_e'(in_if.command);
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);

  // front event leaves the queue: presses at once, releases once aged past debounce
  assign age    = time_q - front_ev.stamp;
  assign commit = (state_q == ST_DRAIN) && front_valid &&
                  (front_ev.press || (age > {{(STAMP_W-DEB_W){1'b0}}, deb_q}));

  assign load_out = (state_q == ST_RESULT) && (!out_valid_q || out_if.ready);

  assign push_ev.stamp = time_q;
  assign push_ev.press = (cmd == CMD_PRESS);
  assign push_ev.key   = in_if.key;

  always_comb begin
    ctl          = '0;
    ctl.scan_clr = accept;
    ctl.shift    = commit;
    ctl.scan_en  = (state_q == ST_SCAN);
    if (accept) begin
      ctl.clear = (cmd == CMD_CLEAR);
      ctl.push  = (cmd == CMD_PRESS) || (cmd == CMD_RELEASE);
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    time_d     = time_q;
    dropped_d  = dropped_q;
    scan_cnt_d = scan_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dropped_d = 1'b0;
          case (cmd) inside
            CMD_TICK:                 time_d    = time_q + STAMP_W'(1);
            CMD_PRESS, CMD_RELEASE:   dropped_d = chain_full;
            default:                  dropped_d = 1'b0;
          endcase
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!commit) begin
          scan_cnt_d = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_cnt_d = scan_cnt_q + CNT_W'(1);
        if (scan_cnt_q == CNT_W'(QUEUE_DEPTH - 1)) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      deb_q      <= DEB_RESET;
      time_q     <= '0;
      dropped_q  <= 1'b0;
      scan_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      time_q     <= time_d;
      dropped_q  <= dropped_d;
      scan_cnt_q <= scan_cnt_d;
      if (cfg_we_i) begin
        deb_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= in_if.key;
    end
  end

  // held map: clear empties it, each committed event writes one key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (ctl.clear) begin
      held_q <= '0;
    end else if (commit) begin
      held_q[front_ev.key] <= front_ev.press;
    end
  end

  // registered read of the queried key while the chain scans
  always_ff @(posedge clk_i) begin
    held_rd_q <= held_q[key_q];
  end

  kdt_event_chain u_chain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .push_ev_i     (push_ev),
    .query_key_i   (key_q),
    .front_valid_o (front_valid),
    .front_ev_o    (front_ev),
    .full_o        (chain_full),
    .hit_o         (chain_hit)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pressed_q <= held_rd_q || chain_hit;
      out_pending_q <= front_valid;
      out_next_q    <= front_valid ?
                       (front_ev.stamp + {{(STAMP_W-DEB_W){1'b0}}, deb_q}) : '0;
      out_dropped_q <= dropped_q;
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.key_pressed      = out_pressed_q;
  assign out_if.change_pending   = out_pending_q;
  assign out_if.next_change_time = out_next_q;
  assign out_if.event_dropped    = out_dropped_q;

  // a press or release that meets a full chain is flagged as dropped
  a_drop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && chain_full && (cmd == CMD_PRESS || cmd == CMD_RELEASE) |=> dropped_q)
    else $error("lost event not flagged");

  // the chain front stays put while the match ripples
  a_scan_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && $past(state_q == ST_SCAN) |-> $stable(front_valid))
    else $error("chain moved during scan");

  // a new result appears only from the result state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result presented outside result state");

  // once drained, the front is never a press
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !(front_valid && front_ev.press))
    else $error("press left at queue front after drain");

endmodule

### dv/kdt_key_state_checker.sv
`timescale 1ns / 1ps
// tracks held keys and the event queue alongside the tracker and checks each result item
// depends on kdt_pkg and the kdt_in_if / kdt_out_if channel interfaces

module kdt_key_state_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  kdt_in_if                         in_mon,
  kdt_out_if                        out_mon,
  input  logic                      cfg_we_i,
  input  logic [kdt_pkg::DEB_W-1:0] cfg_wdata_i,
  output int                        mismatch_count_o,
  output int                        reports_owed_o
);
  import kdt_pkg::*;

  typedef struct packed {
    logic               key_pressed;
    logic               change_pending;
    logic [STAMP_W-1:0] next_change_time;
    logic               event_dropped;
  } key_report_t;

  logic [DEB_W-1:0]   debounce;
  logic [STAMP_W-1:0] time_now;
  logic [KEY_COUNT-1:0] held_keys;
  logic [STAMP_W-1:0] ev_stamp [QUEUE_DEPTH];
  logic               ev_press [QUEUE_DEPTH];
  logic [KEY_W-1:0]   ev_key   [QUEUE_DEPTH];
  logic [3:0]         ev_head;
  int                 ev_count;
  key_report_t        reports_due [$];
  int                 mismatches;

  // apply one item to the tracked state and work out its report
  function automatic key_report_t advance_tracker(cmd_e cmd, logic [KEY_W-1:0] k);
    key_report_t        rep;
    logic [3:0]         slot;
    logic [STAMP_W-1:0] age;
    int                 idx;
    rep = '0;
    case (cmd) inside
      CMD_TICK: begin
        time_now = time_now + 1;
      end
      CMD_PRESS, CMD_RELEASE: begin
        if (ev_count < QUEUE_DEPTH) begin
          slot = ev_head + ev_count[3:0];
          ev_stamp[slot] = time_now;
          ev_press[slot] = (cmd == CMD_PRESS);
          ev_key[slot]   = k;
          ev_count++;
        end else begin
          rep.event_dropped = 1'b1;
        end
      end
      default: begin
        held_keys = '0;
        ev_head   = '0;
        ev_count  = 0;
      end
    endcase
    // presses commit at once, releases once strictly older than the debounce
    while (ev_count != 0) begin
      age = time_now - ev_stamp[ev_head];
      if (ev_press[ev_head]) begin
        held_keys[ev_key[ev_head]] = 1'b1;
      end else if (age > STAMP_W'(debounce)) begin
        held_keys[ev_key[ev_head]] = 1'b0;
      end else begin
        break;
      end
      ev_head = ev_head + 4'd1;
      ev_count--;
    end
    rep.key_pressed = held_keys[k];
    for (idx = 0; idx < ev_count; idx++) begin
      slot = ev_head + idx[3:0];
      if (ev_press[slot] && ev_key[slot] == k) rep.key_pressed = 1'b1;
    end
    rep.change_pending   = (ev_count != 0);
    rep.next_change_time = (ev_count != 0) ? ev_stamp[ev_head] + STAMP_W'(debounce) : '0;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [STAMP_W-1:0] want,
                                      logic [STAMP_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_report_t want;
    if (!rst_ni) begin
      debounce   = DEB_RESET;
      time_now   = '0;
      held_keys  = '0;
      ev_head    = '0;
      ev_count   = 0;
      mismatches = 0;
      reports_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (reports_due.size() == 0) begin
          $display("%0t unexpected result item: expected none actual %0h %0h %0h %0h", $time,
                   out_mon.key_pressed, out_mon.change_pending, out_mon.next_change_time,
                   out_mon.event_dropped);
          mismatches++;
        end else begin
          want = reports_due[0];
          reports_due.delete(0);
          check_field("key_pressed", STAMP_W'(want.key_pressed), STAMP_W'(out_mon.key_pressed));
          check_field("change_pending", STAMP_W'(want.change_pending),
                      STAMP_W'(out_mon.change_pending));
          check_field("next_change_time", want.next_change_time, out_mon.next_change_time);
          check_field("event_dropped", STAMP_W'(want.event_dropped),
                      STAMP_W'(out_mon.event_dropped));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        reports_due.push_back(advance_tracker(cmd_e'(in_mon.command), in_mon.key));
      end
      if (cfg_we_i) debounce = cfg_wdata_i;
    end
    mismatch_count_o <= mismatches;
    reports_owed_o   <= reports_due.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// stimulus and verdict for key_release_debounce_tracker_core
// depends on kdt_pkg, kdt_if, the core and kdt_key_state_checker

module testbench;
  import kdt_pkg::*;

  localparam int QUIET_LIMIT = 5000;   // cycles with no item moving on either channel

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [DEB_W-1:0] cfg_wdata_i;
  int               mismatch_count;
  int               reports_owed;
  int               items_sent;
  int               quiet_cycles;
  bit               rush;               // no idling on either side while set
  logic [KEY_W-1:0] key_pool [8];
  logic [DEB_W-1:0] debounce_now;

  kdt_in_if  in_ch ();
  kdt_out_if out_ch ();

  always #5ns clk_i = ~clk_i;

  key_release_debounce_tracker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  kdt_key_state_checker key_state_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .reports_owed_o   (reports_owed)
  );

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // keys mostly come from a small pool so that queries hit keys in use
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return key_pool[$urandom_range(0, 7)];
    if (roll < 75) return (roll < 70) ? '0 : '1;
    return KEY_W'($urandom_range(0, KEY_COUNT - 1));
  endfunction

  // one item on the input channel, with an optional gap before it
  task automatic issue_key_item(cmd_e cmd, logic [KEY_W-1:0] k);
    int gap;
    gap = rush ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key     <= k;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // hold off the sender until every result item has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (reports_owed != 0);
  endtask

  task automatic set_debounce(logic [DEB_W-1:0] ticks);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= ticks;
    debounce_now = ticks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic tick_run();
    int n;
    n = $urandom_range(0, (debounce_now > 40) ? 6 : debounce_now + 2);
    repeat (n) issue_key_item(CMD_TICK, pick_key());
  endtask

  function automatic logic [DEB_W-1:0] phase_debounce(int phase);
    case (phase)
      0:       return DEB_W'(0);
      1:       return DEB_W'(1);
      2:       return DEB_W'(4);
      3:       return DEB_W'(12);
      4:       return '1;
      5:       return DEB_W'(2);
      default: return DEB_W'(30);
    endcase
  endfunction

  // result side: bursts of ready broken by stalls of random length
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      out_ch.ready <= 1'b1;
      if (rush) begin
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        stall = idle_len();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int phase;
    int target;
    int roll;
    int i;
    logic [KEY_W-1:0] k;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.key     = '0;
    items_sent    = 0;
    quiet_cycles  = 0;
    rush          = 1'b0;
    debounce_now  = DEB_RESET;
    for (i = 0; i < 8; i++) key_pool[i] = KEY_W'($urandom_range(0, KEY_COUNT - 1));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: longest debounce so the first release blocks the queue
    set_debounce('1);
    issue_key_item(CMD_TICK, '1);
    issue_key_item(CMD_PRESS, '0);         // commits at once
    issue_key_item(CMD_RELEASE, '0);       // stuck at the front
    for (i = 0; i < 15; i++) begin
      issue_key_item(CMD_PRESS, (i % 2 == 0) ? KEY_W'('1) : KEY_W'(i * 17));
    end
    // queue full now: both event kinds are lost
    issue_key_item(CMD_PRESS, KEY_W'(8'h81));
    issue_key_item(CMD_RELEASE, KEY_W'(8'h7e));
    issue_key_item(CMD_TICK, '0);
    issue_key_item(CMD_CLEAR, '1);         // empties map and queue, time kept
    // zero debounce: a release commits after a single tick of age
    wait_drained();
    set_debounce('0);
    issue_key_item(CMD_PRESS, KEY_W'(8'h3c));
    issue_key_item(CMD_RELEASE, KEY_W'(8'h3c));
    issue_key_item(CMD_TICK, KEY_W'(8'h3c));

    // random phases, one debounce setting each
    for (phase = 0; phase < 7; phase++) begin
      wait_drained();
      set_debounce(phase_debounce(phase));
      for (i = 0; i < 8; i++) key_pool[i] = KEY_W'($urandom_range(0, KEY_COUNT - 1));
      rush   = (phase == 3);
      target = items_sent + 200;
      while (items_sent < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          // a full keystroke: press, hold a while, release, let it age
          k = pick_key();
          issue_key_item(CMD_PRESS, k);
          tick_run();
          issue_key_item(CMD_RELEASE, k);
          tick_run();
        end else if (roll < 93) begin
          issue_key_item(cmd_e'($urandom_range(0, 2)), KEY_W'($urandom_range(0, KEY_COUNT - 1)));
        end else if (roll < 98) begin
          issue_key_item(CMD_CLEAR, pick_key());
        end else begin
          wait_drained();
        end
      end
    end
    rush = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
